// ----- hdl/cms_pkg.sv -----
// package: shared constants and types for the confusion matrix stats core
`default_nettype none
package cms_pkg;
    localparam int MAX_CLASSES_DEF = 16;
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int CLASS_W         = 5;
    localparam int LABEL_W         = 8;
    localparam int RATIO_W         = 17;
    localparam int OUT_W           = 32;
    localparam logic [CLASS_W-1:0] CLASS_COUNT_RESET = 5'd16;

    typedef enum logic [1:0] {
        CMD_RECORD = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_CELL   = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [LABEL_W-1:0] true_label;
        logic [LABEL_W-1:0] predicted_label;
        logic [LABEL_W-1:0] target_class;
    } in_word_t;

    typedef struct packed {
        logic               status;
        logic [RATIO_W-1:0] accuracy;
        logic [RATIO_W-1:0] precision;
        logic [RATIO_W-1:0] recall;
        logic [RATIO_W-1:0] f1_score;
        logic [OUT_W-1:0]   cell_value;
        logic [OUT_W-1:0]   sample_total;
    } out_word_t;
endpackage
`default_nettype wire

// ----- hdl/cms_if.sv -----
// interface: valid/ready channel carrying one word
`default_nettype none
interface cms_if #(parameter type word_t = logic);
    logic  valid;
    logic  ready;
    word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/confusion_matrix_stats_core.sv -----
// top level: confusion matrix counts, totals and query sequencer
// record, clear and cell read pass through the READ, WRIT and OUT states to the result
// query sums n classes twice through the one read port (row, then column), then
// computes four ratios in turn on one serial divider
// one word in flight at a time; no new word is accepted until the last result is taken
// reset: async, class_count 16; a clearing pass then zeroes every matrix entry
`default_nettype none
module confusion_matrix_stats_core #(
    parameter int MAX_CLASSES = cms_pkg::MAX_CLASSES_DEF,
    parameter int COUNT_WIDTH = cms_pkg::COUNT_WIDTH_DEF,
    parameter int FRAC_BITS   = cms_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [cms_pkg::CLASS_W-1:0] cfg_wdata,
    cms_if.sink                              in_ch,
    cms_if.source                            out_ch
);
    localparam int CW = (MAX_CLASSES > 2) ? $clog2(MAX_CLASSES) : 1;
    localparam int AW = 2 * CW;
    localparam int SW = COUNT_WIDTH + CW + 2;
    localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_READ = 8'b0000_0010,
        ST_WRIT = 8'b0000_0100,
        ST_SUM  = 8'b0000_1000,
        ST_DIAG = 8'b0001_0000,
        ST_DIV  = 8'b0010_0000,
        ST_DWT  = 8'b0100_0000,
        ST_OUT  = 8'b1000_0000
    } state_t;

    state_t                         state_reg;
    cms_pkg::in_word_t              w_reg;
    cms_pkg::out_word_t             o_reg;
    logic                           ovalid_reg;
    logic [cms_pkg::CLASS_W-1:0]    cc_reg;
    logic [COUNT_WIDTH-1:0]         samp_reg, corr_reg;
    logic [SW-1:0]                  row_reg, col_reg;
    logic [COUNT_WIDTH-1:0]         diag_reg;
    logic [8:0]                     k_reg;
    logic                           phase_reg;
    logic [1:0]                     dsel_reg;
    logic [8:0]                     n;
    logic                           tl_ok, pl_ok, tc_ok;
    logic [AW-1:0]                  cell_addr, raddr;
    logic [COUNT_WIDTH-1:0]         rdata;
    logic                           mwe, mclr, mbusy;
    logic                           dstart, ddone;
    logic [SW-1:0]                  dnum, dden;
    logic [cms_pkg::RATIO_W-1:0]    dq;

    // classes in use
    always_comb
    begin
        n = (9'(cc_reg) > 9'(MAX_CLASSES)) ? 9'(MAX_CLASSES) : 9'(cc_reg);
        tl_ok = 9'(w_reg.true_label) < n;
        pl_ok = 9'(w_reg.predicted_label) < n;
        tc_ok = 9'(w_reg.target_class) < n;
        cell_addr = {w_reg.true_label[CW-1:0], w_reg.predicted_label[CW-1:0]};
    end

    // read address selection
    always_comb
    begin
        raddr = cell_addr;
        if (state_reg == ST_SUM)
            raddr = phase_reg ? {k_reg[CW-1:0], w_reg.target_class[CW-1:0]}
                              : {w_reg.target_class[CW-1:0], k_reg[CW-1:0]};
        else if (state_reg == ST_DIAG)
            raddr = {w_reg.target_class[CW-1:0], w_reg.target_class[CW-1:0]};
    end

    assign mwe  = (state_reg == ST_WRIT) && w_reg.cmd == cms_pkg::CMD_RECORD
                  && tl_ok && pl_ok && rdata != CMAX;
    assign mclr = (state_reg == ST_WRIT) && w_reg.cmd == cms_pkg::CMD_CLEAR;

    cms_mem #(.DEPTH(1 << AW), .AW(AW), .DW(COUNT_WIDTH)) u_mem (
        .clk(clk), .rst_n(rst_n), .clear(mclr), .we(mwe), .waddr(cell_addr),
        .wdata(rdata + 1'b1), .raddr(raddr), .rdata(rdata), .busy(mbusy)
    );

    // divider operand selection
    always_comb
    begin
        unique case (dsel_reg)
            2'd0:
            begin
                dnum = SW'(corr_reg);
                dden = SW'(samp_reg);
            end
            2'd1:
            begin
                dnum = SW'(diag_reg);
                dden = col_reg;
            end
            2'd2:
            begin
                dnum = SW'(diag_reg);
                dden = row_reg;
            end
            default:
            begin
                dnum = SW'({diag_reg, 1'b0});
                dden = row_reg + col_reg;
            end
        endcase
    end

    cms_div #(.NW(SW), .FRAC_BITS(FRAC_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .start(dstart), .num(dnum), .den(dden),
        .done(ddone), .quo(dq)
    );

    assign dstart = (state_reg == ST_DIV);
    assign in_ch.ready = (state_reg == ST_IDLE) && !ovalid_reg && !mbusy;
    assign out_ch.valid = ovalid_reg;
    assign out_ch.data = o_reg;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cc_reg <= cms_pkg::CLASS_COUNT_RESET;
        else if (cfg_we)
            cc_reg <= cfg_wdata;
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ovalid_reg <= 1'b0;
            samp_reg <= '0;
            corr_reg <= '0;
            k_reg <= '0;
            phase_reg <= 1'b0;
            dsel_reg <= '0;
            w_reg <= '0;
            o_reg <= '0;
            row_reg <= '0;
            col_reg <= '0;
            diag_reg <= '0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
                ovalid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_ch.valid && in_ch.ready)
                    begin
                        w_reg <= in_ch.data;
                        o_reg <= '0;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    if (w_reg.cmd == cms_pkg::CMD_QUERY && tc_ok)
                    begin
                        row_reg <= '0;
                        col_reg <= '0;
                        k_reg <= '0;
                        phase_reg <= 1'b0;
                        state_reg <= ST_SUM;
                    end
                    else
                        state_reg <= ST_WRIT;
                end
                ST_WRIT:
                begin
                    if (w_reg.cmd == cms_pkg::CMD_RECORD && tl_ok && pl_ok)
                    begin
                        if (samp_reg != CMAX)
                            samp_reg <= samp_reg + 1'b1;
                        if (w_reg.true_label == w_reg.predicted_label && corr_reg != CMAX)
                            corr_reg <= corr_reg + 1'b1;
                    end
                    else if (w_reg.cmd == cms_pkg::CMD_CLEAR)
                    begin
                        samp_reg <= '0;
                        corr_reg <= '0;
                    end
                    if (w_reg.cmd == cms_pkg::CMD_CELL && tl_ok && pl_ok)
                        o_reg.cell_value <= (COUNT_WIDTH > cms_pkg::OUT_W
                            && (SW'(rdata) > SW'(33'hFFFF_FFFF))) ? '1
                            : cms_pkg::OUT_W'(rdata);
                    o_reg.status <= (w_reg.cmd == cms_pkg::CMD_RECORD
                        || w_reg.cmd == cms_pkg::CMD_CELL) ? !(tl_ok && pl_ok)
                        : (w_reg.cmd == cms_pkg::CMD_QUERY);
                    state_reg <= ST_OUT;
                end
                ST_SUM:
                begin
                    // data from previous cycle's address
                    if (k_reg != 9'd0 || phase_reg)
                    begin
                        if (phase_reg && k_reg == 9'd0)
                            row_reg <= row_reg + SW'(rdata);
                        else if (phase_reg)
                            col_reg <= col_reg + SW'(rdata);
                        else
                            row_reg <= row_reg + SW'(rdata);
                    end
                    if (k_reg == n - 9'd1)
                    begin
                        k_reg <= '0;
                        if (phase_reg)
                            state_reg <= ST_DIAG;
                        else
                            phase_reg <= 1'b1;
                    end
                    else
                        k_reg <= k_reg + 9'd1;
                end
                ST_DIAG:
                begin
                    col_reg <= col_reg + SW'(rdata);
                    dsel_reg <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    // diagonal count arrives on the first pass only
                    if (dsel_reg == 2'd0)
                        diag_reg <= rdata;
                    state_reg <= ST_DWT;
                end
                ST_DWT:
                begin
                    // collect one ratio, then start the next or finish
                    if (ddone)
                    begin
                        case (dsel_reg)
                            2'd0: o_reg.accuracy <= dq;
                            2'd1: o_reg.precision <= dq;
                            2'd2: o_reg.recall <= dq;
                            default: o_reg.f1_score <= dq;
                        endcase
                        dsel_reg <= dsel_reg + 2'd1;
                        state_reg <= (dsel_reg == 2'd3) ? ST_OUT : ST_DIV;
                    end
                end
                default:
                begin
                    if (!ovalid_reg)
                    begin
                        o_reg.sample_total <= (COUNT_WIDTH > cms_pkg::OUT_W
                            && (SW'(samp_reg) > SW'(33'hFFFF_FFFF))) ? '1
                            : cms_pkg::OUT_W'(samp_reg);
                        ovalid_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // an accepted word always takes the core out of the ready state
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> !in_ch.ready)
        else $error("accepted while busy");
    // correct count never exceeds sample count
    a_corr_le_samp: assert property (@(posedge clk) disable iff (!rst_n)
        corr_reg <= samp_reg)
        else $error("correct count above sample count");
    // memory is never written outside a record write
    a_write_only_record: assert property (@(posedge clk) disable iff (!rst_n)
        mwe |-> state_reg == ST_WRIT && w_reg.cmd == cms_pkg::CMD_RECORD)
        else $error("stray matrix write");
`endif
endmodule
`default_nettype wire

// ----- hdl/cms_div.sv -----
// divider: restoring fractional ratio, one quotient bit per cycle
`default_nettype none
module cms_div #(
    parameter int NW = 34,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [NW-1:0]          num,
    input  wire logic [NW-1:0]          den,
    output logic                        done,
    output logic [cms_pkg::RATIO_W-1:0] quo
);
    localparam int CW = $clog2(FRAC_BITS + 1);
    logic [NW:0]                 rem_reg, rem_next;
    logic [NW-1:0]               den_reg;
    logic [FRAC_BITS:0]          q_reg, q_next;
    logic [CW-1:0]               cnt_reg;
    logic                        busy_reg;
    logic [NW:0]                 sh;

    // one shift-subtract step
    always_comb
    begin
        sh = {rem_reg[NW-1:0], 1'b0};
        rem_next = sh;
        q_next = {q_reg[FRAC_BITS-1:0], 1'b0};
        if (sh >= {1'b0, den_reg})
        begin
            rem_next = sh - {1'b0, den_reg};
            q_next[0] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done <= 1'b0;
            cnt_reg <= '0;
            rem_reg <= '0;
            den_reg <= '0;
            q_reg <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b0;
                if (den == '0)
                begin
                    q_reg <= '0;
                    done <= 1'b1;
                end
                else if (num >= den)
                begin
                    q_reg <= (FRAC_BITS+1)'(1) << FRAC_BITS;
                    done <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                    rem_reg <= {1'b0, num};
                    den_reg <= den;
                    q_reg <= '0;
                    cnt_reg <= CW'(FRAC_BITS);
                end
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                q_reg <= q_next;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done <= 1'b1;
                end
            end
        end
    end

    assign quo = cms_pkg::RATIO_W'(q_reg);
endmodule
`default_nettype wire

// ----- hdl/cms_mem.sv -----
// count matrix memory with a clearing pass after reset and on clear
`default_nettype none
module cms_mem #(
    parameter int DEPTH = 256,
    parameter int AW = 8,
    parameter int DW = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          clear,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic [DW-1:0]      rdata,
    output logic               busy
);
    logic [DW-1:0]    mem [DEPTH];
    logic [DW-1:0]    rd_reg;
    logic             busy_reg;
    logic [AW-1:0]    caddr_reg;

    // storage, no reset; the clearing pass writes zeros one entry a cycle
    always_ff @(posedge clk)
    begin
        if (busy_reg)
            mem[caddr_reg] <= '0;
        else if (we)
            mem[waddr] <= wdata;
        rd_reg <= mem[raddr];
    end

    // clearing pass walks every entry once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            caddr_reg <= '0;
        end
        else if (clear)
        begin
            busy_reg <= 1'b1;
            caddr_reg <= '0;
        end
        else if (busy_reg)
        begin
            caddr_reg <= caddr_reg + 1'b1;
            if (caddr_reg == AW'(DEPTH - 1))
                busy_reg <= 1'b0;
        end
    end

    assign rdata = rd_reg;
    assign busy = busy_reg;
endmodule
`default_nettype wire
